>>> sv/double_ended_queue_macros.svh
// assertion macros for the double-ended queue
// expects clock aclk and active-low reset aresetn in the including module
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// check that holds only outside reset
`define DEQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deque check failed");

// check that holds at every edge, reset included
`define DEQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("deque check failed");

`endif

>>> sv/deq_pkg.sv
// types and constants shared by the double-ended queue modules
// no dependencies
`default_nettype none

package deq_pkg;

    localparam int VALUE_W    = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } bk_state_t;

    typedef struct packed {
        opcode_t                    op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

>>> sv/deq_front.sv
// front end: takes input words, drops unknown opcodes, builds commands
// depends on deq_pkg
`default_nettype none

module deq_front (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic signed [deq_pkg::VALUE_W-1:0] s_tdata,  // push_value
    input  wire logic [deq_pkg::OP_W-1:0]          s_tuser,  // opcode
    output logic                                   enq_valid,
    input  wire logic                              enq_ready,
    output deq_pkg::cmd_t                          enq_cmd
);

    logic op_known;
    logic op_push;

    assign op_known = s_tuser inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK,
                                      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
                                      deq_pkg::OP_DUMP};
    assign op_push  = s_tuser inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK};

    assign s_tready      = enq_ready;
    assign enq_valid     = s_tvalid && op_known;
    assign enq_cmd.op    = deq_pkg::opcode_t'(s_tuser);
    assign enq_cmd.value = op_push ? s_tdata : '0;

endmodule

`default_nettype wire

>>> sv/deq_cmdq.sv
// short command queue between front end and execution unit
// depends on deq_pkg
`default_nettype none

module deq_cmdq (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          enq_valid,
    output logic               enq_ready,
    input  wire deq_pkg::cmd_t enq_cmd,
    output logic               deq_valid,
    input  wire logic          deq_ready,
    output deq_pkg::cmd_t      deq_cmd
);

    localparam int PTR_W = (deq_pkg::CMDQ_DEPTH > 1) ? $clog2(deq_pkg::CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(deq_pkg::CMDQ_DEPTH + 1);

    deq_pkg::cmd_t    slot_reg [deq_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_enq, do_deq;

    assign enq_ready = count_reg != CNT_W'(deq_pkg::CMDQ_DEPTH);
    assign deq_valid = count_reg != '0;
    assign deq_cmd   = slot_reg[rd_ptr_reg];
    assign do_enq    = enq_valid && enq_ready;
    assign do_deq    = deq_valid && deq_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_enq) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(deq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_deq) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(deq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_enq && !do_deq) begin
            count_next = count_reg + 1'b1;
        end else if (!do_enq && do_deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_enq) begin
            slot_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/deq_back.sv
// execution unit: ring buffer storage, end pointers, dump sequencer, output register
// depends on deq_pkg and double_ended_queue_macros.svh
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_back #(
    parameter int DEPTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cmd_valid,
    output logic                                    cmd_ready,
    input  wire deq_pkg::cmd_t                      cmd,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic signed [deq_pkg::VALUE_W-1:0]      m_tdata,  // out_value
    output logic [deq_pkg::STATUS_W-1:0]            m_tuser,  // status
    output logic                                    m_tlast
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    logic signed [deq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [deq_pkg::VALUE_W-1:0] rd_data_reg;

    deq_pkg::bk_state_t state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [IDX_W-1:0]   back_reg, back_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [OCC_W-1:0]   left_reg, left_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;

    logic                               out_valid_reg, out_valid_next;
    deq_pkg::status_t                   out_status_reg;
    logic signed [deq_pkg::VALUE_W-1:0] out_value_reg;
    logic                               out_last_reg;

    logic             out_free, take, q_empty, q_full;
    logic             load, load_mem;
    deq_pkg::status_t load_status;
    logic             load_last;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec, addr_inc;
    int               ends_sum;

    assign out_free  = !out_valid_reg || m_tready;
    assign take      = (state_reg == deq_pkg::BK_IDLE) && cmd_valid && out_free;
    assign cmd_ready = take;
    assign q_empty   = occ_reg == '0;
    assign q_full    = occ_reg == OCC_W'(DEPTH);

    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign back_inc  = (back_reg == IDX_W'(DEPTH - 1)) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? IDX_W'(DEPTH - 1) : back_reg - 1'b1;
    assign addr_inc  = (addr_reg == IDX_W'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    assign ends_sum  = 32'(front_reg) + 32'(occ_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::BK_IDLE: begin
                if (take && !q_empty && (cmd.op inside {deq_pkg::OP_POP_FRONT,
                                         deq_pkg::OP_POP_BACK, deq_pkg::OP_DUMP})) begin
                    state_next = deq_pkg::BK_EMIT;
                end
            end
            deq_pkg::BK_EMIT: begin
                if (out_free && left_reg == '0) begin
                    state_next = deq_pkg::BK_IDLE;
                end
            end
            default: state_next = deq_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        occ_next    = occ_reg;
        left_next   = left_reg;
        addr_next   = addr_reg;
        load        = 1'b0;
        load_mem    = 1'b0;
        load_status = deq_pkg::ST_OK;
        load_last   = 1'b1;
        wr_en       = 1'b0;
        wr_addr     = back_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        case (state_reg)
            deq_pkg::BK_IDLE: begin
                if (take) begin
                    case (cmd.op)
                        deq_pkg::OP_PUSH_FRONT: begin
                            load = 1'b1;
                            if (q_full) begin
                                load_status = deq_pkg::ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_PUSH_BACK: begin
                            load = 1'b1;
                            if (q_full) begin
                                load_status = deq_pkg::ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = back_reg;
                                back_next = back_inc;
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (q_empty) begin
                                load        = 1'b1;
                                load_status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                front_next = front_inc;
                                occ_next   = occ_reg - 1'b1;
                                left_next  = '0;
                            end
                        end
                        deq_pkg::OP_POP_BACK: begin
                            if (q_empty) begin
                                load        = 1'b1;
                                load_status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = back_dec;
                                back_next = back_dec;
                                occ_next  = occ_reg - 1'b1;
                                left_next = '0;
                            end
                        end
                        deq_pkg::OP_DUMP: begin
                            if (q_empty) begin
                                load        = 1'b1;
                                load_status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = front_reg;
                                addr_next = front_reg;
                                left_next = occ_reg - 1'b1;
                            end
                        end
                        default: begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            deq_pkg::BK_EMIT: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_mem  = 1'b1;
                    load_last = left_reg == '0;
                    if (left_reg != '0) begin
                        rd_en     = 1'b1;
                        rd_addr   = addr_inc;
                        addr_next = addr_inc;
                        left_next = left_reg - 1'b1;
                    end
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= deq_pkg::BK_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            occ_reg       <= '0;
            left_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            occ_reg       <= occ_next;
            left_reg      <= left_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_status_reg <= load_status;
            out_value_reg  <= load_mem ? rd_data_reg : '0;
            out_last_reg   <= load_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `DEQ_ASSERT_ALWAYS(a_occ_bound, (!aresetn || occ_reg <= OCC_W'(DEPTH)))
    `DEQ_ASSERT(a_load_free, (load |-> out_free))
    `DEQ_ASSERT(a_no_write_in_emit, (wr_en |-> state_reg == deq_pkg::BK_IDLE))
    `DEQ_ASSERT(a_ends_agree, (ends_sum == 32'(back_reg) || ends_sum == 32'(back_reg) + DEPTH))
    `DEQ_ASSERT(a_dump_in_range, ((state_reg == deq_pkg::BK_EMIT && left_reg != '0) |-> left_reg < occ_reg))

endmodule

`default_nettype wire

>>> sv/double_ended_queue.sv
// double-ended queue of signed 32-bit words on a ring buffer of DEPTH entries
// depends on deq_pkg, deq_front, deq_cmdq, deq_back
//
// usage:
//   s_ channel carries one operation per word: s_tuser is the opcode (push front,
//   push back, pop front, pop back, dump), s_tdata the value a push stores.
//   unknown opcodes are taken and give no result.
//   m_ channel returns results: m_tuser is the status (ok, empty, full),
//   m_tdata the popped or dumped value, m_tlast marks the final result of an op.
//   a two-entry command queue sits between the front end and the execution unit,
//   so input words are still taken, until it is full, while a result waits on m_tready.
//   a push writes storage and loads its result into the output register directly;
//   a pop or dump first goes through the registered storage read, and a dump then
//   gives one result per stored word, the last with m_tlast set.
//   the execution unit has one storage read port and a single output register.
//   reset (aresetn low at a clock edge) empties the queue and drops pending words.
//   when m_tready is low with a result held, the output register holds and the execution unit waits.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic signed [deq_pkg::VALUE_W-1:0]  s_tdata,  // push_value
    input  wire logic [deq_pkg::OP_W-1:0]            s_tuser,  // opcode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic signed [deq_pkg::VALUE_W-1:0]       m_tdata,  // out_value
    output logic [deq_pkg::STATUS_W-1:0]             m_tuser,  // status
    output logic                                     m_tlast
);

    logic          enq_valid, enq_ready;
    deq_pkg::cmd_t enq_cmd;
    logic          deq_valid, deq_ready;
    deq_pkg::cmd_t deq_cmd;

    deq_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_cmd   (enq_cmd)
    );

    deq_cmdq u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enq_valid (enq_valid),
        .enq_ready (enq_ready),
        .enq_cmd   (enq_cmd),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_cmd   (deq_cmd)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (deq_valid),
        .cmd_ready (deq_ready),
        .cmd       (deq_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
